/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define PPI_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Condition must never be seen at a clock edge outside reset.
`define PPI_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);
`else
`define PPI_ASSERT(lbl, clk, rst_n, prop, msg)
`define PPI_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

/* hw/rtl/ppi_pkg.sv */
`default_nettype none
package ppi_pkg;

	localparam int unsigned CFG_IDX_W = 4;
	localparam int unsigned PC_W      = 6;
	localparam int unsigned UCODE_LEN = 40;
	// The Euler program occupies the first entries, the midpoint program follows.
	localparam logic [PC_W-1:0] EULER_START = 6'd0;
	localparam logic [PC_W-1:0] RK2_START   = 6'd13;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PREY_GROWTH    = 4'd0,
		REG_PREDATION_RATE = 4'd1,
		REG_PREDATOR_GAIN  = 4'd2,
		REG_PREDATOR_DEATH = 4'd3,
		REG_TIME_STEP      = 4'd4,
		REG_METHOD         = 4'd5,
		REG_START_TIME     = 4'd6,
		REG_END_TIME       = 4'd7
	} cfg_reg_t;

	typedef enum logic {
		CMD_RESTART = 1'b0,
		CMD_STEP    = 1'b1
	} cmd_code_t;

	typedef enum logic {
		METHOD_EULER = 1'b0,
		METHOD_RK2   = 1'b1
	} method_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MULW,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		OP_MUL,
		OP_ADD,
		OP_SUB,
		OP_HALF
	} uop_code_t;

	typedef enum logic [3:0] {
		SRC_X, SRC_Y, SRC_T0, SRC_T1, SRC_T2, SRC_T3, SRC_TM,
		SRC_A, SRC_B, SRC_C, SRC_D, SRC_DT
	} src_sel_t;

	typedef enum logic [2:0] {
		DST_X, DST_Y, DST_T0, DST_T1, DST_T2, DST_T3, DST_TM
	} dst_sel_t;

	typedef struct packed {
		uop_code_t op;
		src_sel_t  src_a;
		src_sel_t  src_b;
		dst_sel_t  dst;
		logic      last;
	} uop_t;

	typedef struct packed {
		cmd_code_t          command;
		logic signed [31:0] init_prey;
		logic signed [31:0] init_pred;
	} cmd_item_t;

	typedef struct packed {
		logic signed [31:0] step_time;
		logic signed [31:0] prey_value;
		logic signed [31:0] pred_value;
		logic               done_res;
		logic               saturated;
	} res_item_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic               clamp;
	} sat_t;

	function automatic sat_t sat32(input logic signed [63:0] v);
		sat_t r;
		if (v > 64'sh000000007fffffff) begin
			r.value = 32'sh7fffffff;
			r.clamp = 1'b1;
		end else if (v < -64'sh0000000080000000) begin
			r.value = 32'sh80000000;
			r.clamp = 1'b1;
		end else begin
			r.value = v[31:0];
			r.clamp = 1'b0;
		end
		return r;
	endfunction

	function automatic uop_t mk(input uop_code_t op, input src_sel_t a, input src_sel_t b,
			input dst_sel_t d, input logic last);
		uop_t u;
		u.op    = op;
		u.src_a = a;
		u.src_b = b;
		u.dst   = d;
		u.last  = last;
		return u;
	endfunction

	// Microcode. Euler: prey rate and update, then predator rate on the new prey and update.
	// Midpoint: k1 for both, midpoint values in T2/T3, then both updates. Each ends with a time advance.
	function automatic uop_t ucode(input logic [PC_W-1:0] pc);
		uop_t u;
		case (pc)
			6'd0:  u = mk(OP_MUL,  SRC_A,  SRC_X,  DST_T0, 1'b0);
			6'd1:  u = mk(OP_MUL,  SRC_B,  SRC_X,  DST_T1, 1'b0);
			6'd2:  u = mk(OP_MUL,  SRC_T1, SRC_Y,  DST_T1, 1'b0);
			6'd3:  u = mk(OP_SUB,  SRC_T0, SRC_T1, DST_T0, 1'b0);
			6'd4:  u = mk(OP_MUL,  SRC_T0, SRC_DT, DST_T0, 1'b0);
			6'd5:  u = mk(OP_ADD,  SRC_X,  SRC_T0, DST_X,  1'b0);
			6'd6:  u = mk(OP_MUL,  SRC_C,  SRC_X,  DST_T0, 1'b0);
			6'd7:  u = mk(OP_MUL,  SRC_T0, SRC_Y,  DST_T0, 1'b0);
			6'd8:  u = mk(OP_MUL,  SRC_D,  SRC_Y,  DST_T1, 1'b0);
			6'd9:  u = mk(OP_SUB,  SRC_T0, SRC_T1, DST_T0, 1'b0);
			6'd10: u = mk(OP_MUL,  SRC_T0, SRC_DT, DST_T0, 1'b0);
			6'd11: u = mk(OP_ADD,  SRC_Y,  SRC_T0, DST_Y,  1'b0);
			6'd12: u = mk(OP_ADD,  SRC_TM, SRC_DT, DST_TM, 1'b1);
			6'd13: u = mk(OP_MUL,  SRC_A,  SRC_X,  DST_T0, 1'b0);
			6'd14: u = mk(OP_MUL,  SRC_B,  SRC_X,  DST_T1, 1'b0);
			6'd15: u = mk(OP_MUL,  SRC_T1, SRC_Y,  DST_T1, 1'b0);
			6'd16: u = mk(OP_SUB,  SRC_T0, SRC_T1, DST_T0, 1'b0);
			6'd17: u = mk(OP_MUL,  SRC_T0, SRC_DT, DST_T0, 1'b0);
			6'd18: u = mk(OP_MUL,  SRC_C,  SRC_X,  DST_T1, 1'b0);
			6'd19: u = mk(OP_MUL,  SRC_T1, SRC_Y,  DST_T1, 1'b0);
			6'd20: u = mk(OP_MUL,  SRC_D,  SRC_Y,  DST_T2, 1'b0);
			6'd21: u = mk(OP_SUB,  SRC_T1, SRC_T2, DST_T1, 1'b0);
			6'd22: u = mk(OP_MUL,  SRC_T1, SRC_DT, DST_T1, 1'b0);
			6'd23: u = mk(OP_HALF, SRC_T0, SRC_T0, DST_T0, 1'b0);
			6'd24: u = mk(OP_ADD,  SRC_X,  SRC_T0, DST_T2, 1'b0);
			6'd25: u = mk(OP_HALF, SRC_T1, SRC_T1, DST_T1, 1'b0);
			6'd26: u = mk(OP_ADD,  SRC_Y,  SRC_T1, DST_T3, 1'b0);
			6'd27: u = mk(OP_MUL,  SRC_A,  SRC_T2, DST_T0, 1'b0);
			6'd28: u = mk(OP_MUL,  SRC_B,  SRC_T2, DST_T1, 1'b0);
			6'd29: u = mk(OP_MUL,  SRC_T1, SRC_T3, DST_T1, 1'b0);
			6'd30: u = mk(OP_SUB,  SRC_T0, SRC_T1, DST_T0, 1'b0);
			6'd31: u = mk(OP_MUL,  SRC_T0, SRC_DT, DST_T0, 1'b0);
			6'd32: u = mk(OP_ADD,  SRC_X,  SRC_T0, DST_X,  1'b0);
			6'd33: u = mk(OP_MUL,  SRC_C,  SRC_T2, DST_T0, 1'b0);
			6'd34: u = mk(OP_MUL,  SRC_T0, SRC_T3, DST_T0, 1'b0);
			6'd35: u = mk(OP_MUL,  SRC_D,  SRC_T3, DST_T1, 1'b0);
			6'd36: u = mk(OP_SUB,  SRC_T0, SRC_T1, DST_T0, 1'b0);
			6'd37: u = mk(OP_MUL,  SRC_T0, SRC_DT, DST_T0, 1'b0);
			6'd38: u = mk(OP_ADD,  SRC_Y,  SRC_T0, DST_Y,  1'b0);
			6'd39: u = mk(OP_ADD,  SRC_TM, SRC_DT, DST_TM, 1'b1);
			default: u = mk(OP_ADD, SRC_TM, SRC_DT, DST_TM, 1'b1);
		endcase
		return u;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/predator_prey_integrator.sv */
// A restart, or a step at or past the end time, skips the arithmetic and goes to the result
// register; an Euler step runs 13 micro-ops (8 multiplies), a midpoint step 27 (16).
// One transaction at a time on the shared multiply/add unit: a new command is taken only
// once the result of the last one has been loaded into the output register.
// Reset (arst_n low, asynchronous): coefficients return to 1.0, dt to 0.1, method to Euler,
// start time to 0, end time to 40.0, populations and time to 0, and no result is pending.
`default_nettype none
`include "assert_macros.svh"
module predator_prey_integrator
	import ppi_pkg::*;
#(
	parameter int FRAC_BITS = 20
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data,
	input  wire logic                 cmd_valid,
	output logic                      cmd_stall,
	input  wire cmd_item_t            cmd,
	output logic                      res_valid,
	input  wire logic                 res_stall,
	output res_item_t                 res
);

	// Reset values of the fixed-point registers follow the binary point position.
	localparam longint ONE_W        = longint'(1) <<< FRAC_BITS;
	localparam longint DT_W         = (ONE_W + 5) / 10;
	localparam longint END_W        = 40 * ONE_W;
	localparam logic signed [31:0] ONE_RESET = 32'(ONE_W);
	localparam logic [30:0]        DT_RESET  = 31'(DT_W);
	localparam logic signed [31:0] END_RESET =
		(END_W > longint'(32'h7fffffff)) ? 32'sh7fffffff : 32'(END_W);

	// Configuration registers. Writes must only arrive while the block is idle; the block
	// itself does not enforce this, and the port is always ready.
	logic signed [31:0] a_q, b_q, c_q, d_q, start_q, end_q;
	logic [30:0]        dt_q;
	method_t            method_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q      <= ONE_RESET;
			b_q      <= ONE_RESET;
			c_q      <= ONE_RESET;
			d_q      <= ONE_RESET;
			dt_q     <= DT_RESET;
			method_q <= METHOD_EULER;
			start_q  <= '0;
			end_q    <= END_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_PREY_GROWTH:    a_q      <= cfg_data;
				REG_PREDATION_RATE: b_q      <= cfg_data;
				REG_PREDATOR_GAIN:  c_q      <= cfg_data;
				REG_PREDATOR_DEATH: d_q      <= cfg_data;
				REG_TIME_STEP:      dt_q     <= cfg_data[30:0];
				REG_METHOD:         method_q <= method_t'(cfg_data[0]);
				REG_START_TIME:     start_q  <= cfg_data;
				REG_END_TIME:       end_q    <= cfg_data;
				default: begin
					// Indexes beyond the register list are dropped.
				end
			endcase
		end
	end

	// Architectural state (prey, predator, time) and the scratch registers used by
	// the micro-op programs.
	logic signed [31:0] x_q, y_q, tm_q;
	logic signed [31:0] t0_q, t1_q, t2_q, t3_q;
	logic signed [31:0] step_time_q;
	logic               done_q;
	logic               sat_q;
	logic [PC_W-1:0]    pc_q;
	state_t             state_q, state_nxt;

	uop_t uop;
	assign uop = ucode(pc_q);

	// Operand selection for the shared unit.
	logic signed [31:0] opa, opb;

	function automatic logic signed [31:0] pick(input src_sel_t s,
			input logic signed [31:0] x, input logic signed [31:0] y,
			input logic signed [31:0] t0, input logic signed [31:0] t1,
			input logic signed [31:0] t2, input logic signed [31:0] t3,
			input logic signed [31:0] tm, input logic signed [31:0] ca,
			input logic signed [31:0] cb, input logic signed [31:0] cc,
			input logic signed [31:0] cd, input logic signed [31:0] dt);
		logic signed [31:0] r;
		case (s)
			SRC_X:   r = x;
			SRC_Y:   r = y;
			SRC_T0:  r = t0;
			SRC_T1:  r = t1;
			SRC_T2:  r = t2;
			SRC_T3:  r = t3;
			SRC_TM:  r = tm;
			SRC_A:   r = ca;
			SRC_B:   r = cb;
			SRC_C:   r = cc;
			SRC_D:   r = cd;
			SRC_DT:  r = dt;
			default: r = '0;
		endcase
		return r;
	endfunction

	always_comb begin
		opa = pick(uop.src_a, x_q, y_q, t0_q, t1_q, t2_q, t3_q, tm_q,
			a_q, b_q, c_q, d_q, {1'b0, dt_q});
		opb = pick(uop.src_b, x_q, y_q, t0_q, t1_q, t2_q, t3_q, tm_q,
			a_q, b_q, c_q, d_q, {1'b0, dt_q});
	end

	// The shared unit. A multiply registers its full 64-bit product in ST_EXEC and scales and
	// saturates it in ST_MULW; add, subtract and halve write back straight from ST_EXEC.
	logic signed [63:0] prod_s1;
	logic signed [63:0] prod_c;
	logic signed [63:0] prod_sh;
	logic signed [32:0] sum_c;
	sat_t               mul_sat, add_sat;

	assign prod_c  = opa * opb;
	assign prod_sh = prod_s1 >>> FRAC_BITS;
	assign sum_c   = (uop.op == OP_SUB) ? ({opa[31], opa} - {opb[31], opb})
					: ({opa[31], opa} + {opb[31], opb});
	assign mul_sat = sat32(prod_sh);
	assign add_sat = sat32(64'(sum_c));

	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC && uop.op == OP_MUL) begin
			prod_s1 <= prod_c;
		end
	end

	// Sequencer outputs.
	logic               accept;
	logic               wb_en;
	logic signed [31:0] wb_val;
	logic               wb_clamp;
	logic               pc_inc;
	logic               res_load;
	logic               step_go;

	assign accept  = cmd_valid && !cmd_stall;
	assign step_go = accept && cmd.command == CMD_STEP && $signed(tm_q) < $signed(end_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd_stall = 1'b1;
		wb_en     = 1'b0;
		wb_val    = add_sat.value;
		wb_clamp  = add_sat.clamp;
		pc_inc    = 1'b0;
		res_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd_stall = 1'b0;
				if (step_go) begin
					state_nxt = ST_EXEC;
				end else if (accept) begin
					// Restart or a step at or past the end time: no arithmetic.
					state_nxt = ST_FINISH;
				end
			end
			ST_EXEC: begin
				case (uop.op)
					OP_MUL: begin
						state_nxt = ST_MULW;
					end
					OP_HALF: begin
						wb_en    = 1'b1;
						wb_val   = opa >>> 1;
						wb_clamp = 1'b0;
					end
					default: begin
						wb_en = 1'b1;
					end
				endcase
				if (uop.op != OP_MUL) begin
					if (uop.last) begin
						state_nxt = ST_FINISH;
					end else begin
						pc_inc = 1'b1;
					end
				end
			end
			ST_MULW: begin
				wb_en    = 1'b1;
				wb_val   = mul_sat.value;
				wb_clamp = mul_sat.clamp;
				if (uop.last) begin
					state_nxt = ST_FINISH;
				end else begin
					pc_inc    = 1'b1;
					state_nxt = ST_EXEC;
				end
			end
			ST_FINISH: begin
				if (!res_valid || !res_stall) begin
					res_load  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q  <= '0;
			y_q  <= '0;
			tm_q <= '0;
		end else if (accept && cmd.command == CMD_RESTART) begin
			x_q  <= cmd.init_prey;
			y_q  <= cmd.init_pred;
			tm_q <= start_q;
		end else if (wb_en) begin
			case (uop.dst)
				DST_X:  x_q  <= wb_val;
				DST_Y:  y_q  <= wb_val;
				DST_TM: tm_q <= wb_val;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wb_en) begin
			case (uop.dst)
				DST_T0: t0_q <= wb_val;
				DST_T1: t1_q <= wb_val;
				DST_T2: t2_q <= wb_val;
				DST_T3: t3_q <= wb_val;
				default: begin
				end
			endcase
		end
		if (accept) begin
			step_time_q <= (cmd.command == CMD_RESTART) ? start_q : tm_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= EULER_START;
			done_q <= 1'b0;
			sat_q  <= 1'b0;
		end else if (accept) begin
			pc_q   <= (method_q == METHOD_RK2) ? RK2_START : EULER_START;
			done_q <= (cmd.command == CMD_STEP) && !step_go;
			sat_q  <= 1'b0;
		end else begin
			if (pc_inc) begin
				pc_q <= pc_q + 1'b1;
			end
			if (wb_en && wb_clamp) begin
				sat_q <= 1'b1;
			end
		end
	end

	// Output register: a finished result waits here until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (res_load) begin
			res_valid <= 1'b1;
		end else if (!res_stall) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res.step_time  <= step_time_q;
			res.prey_value <= x_q;
			res.pred_value <= y_q;
			res.done_res   <= done_q;
			res.saturated  <= sat_q;
		end
	end

	`PPI_ASSERT(a_pc_in_range, clk, arst_n, (state_q == ST_EXEC) |-> (pc_q < UCODE_LEN), "micro-op counter ran past the program")
	`PPI_ASSERT(a_mulw_after_exec, clk, arst_n, (state_q == ST_MULW) |-> ($past(state_q) == ST_EXEC), "multiply writeback without a multiply")
	`PPI_ASSERT(a_finish_to_idle, clk, arst_n, (state_q == ST_FINISH && res_load) |=> (state_q == ST_IDLE && res_valid), "finished result not presented")
	`PPI_NEVER(a_done_not_sat, clk, arst_n, res_valid && res.done_res && res.saturated, "refused step reported saturation")

endmodule
`default_nettype wire

/* test/ppi_checker.sv */
`timescale 1ns / 100ps
module ppi_checker
	import ppi_pkg::*;
#(
	parameter int FRAC_BITS = 20
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	input  wire logic                 cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data,
	input  wire logic                 cmd_valid,
	input  wire logic                 cmd_stall,
	input  wire cmd_item_t            cmd,
	input  wire logic                 res_valid,
	input  wire logic                 res_stall,
	input  wire res_item_t            res,
	output int                        fail_count,
	output int                        pending,
	output int                        restarts,
	output int                        euler_steps,
	output int                        rk2_steps,
	output int                        refused,
	output int                        clamped
);

	typedef logic signed [31:0] fix_t;

	localparam fix_t FIX_MAX = 32'sh7fffffff;
	localparam fix_t FIX_MIN = 32'sh80000000;
	localparam fix_t UNITY   = fix_t'(1 << FRAC_BITS);

	fix_t      coef_a, coef_b, coef_c, coef_d, dt, t_start, t_end;
	method_t   method;
	fix_t      prey, pred, now;
	bit        clipped;
	res_item_t awaited[$];
	res_item_t want;
	res_item_t got;

	function automatic fix_t clip(input longint v);
		if (v > longint'(FIX_MAX)) begin
			clipped = 1'b1;
			return FIX_MAX;
		end
		if (v < longint'(FIX_MIN)) begin
			clipped = 1'b1;
			return FIX_MIN;
		end
		return fix_t'(v);
	endfunction

	// The full product is floored by the arithmetic shift before clamping.
	function automatic fix_t fmul(input fix_t x, input fix_t y);
		return clip((longint'(x) * longint'(y)) >>> FRAC_BITS);
	endfunction

	function automatic fix_t fadd(input fix_t x, input fix_t y);
		return clip(longint'(x) + longint'(y));
	endfunction

	function automatic fix_t fsub(input fix_t x, input fix_t y);
		return clip(longint'(x) - longint'(y));
	endfunction

	function automatic fix_t prey_slope(input fix_t x, input fix_t y);
		return fsub(fmul(coef_a, x), fmul(fmul(coef_b, x), y));
	endfunction

	function automatic fix_t pred_slope(input fix_t x, input fix_t y);
		return fsub(fmul(fmul(coef_c, x), y), fmul(coef_d, y));
	endfunction

	// Applies one command to the local copy of the populations and time.
	function automatic res_item_t integrate(input cmd_item_t item);
		res_item_t r;
		fix_t x, y, nx, ny, kx, ky, xm, ym;
		clipped    = 1'b0;
		r.done_res = 1'b0;
		if (item.command == CMD_RESTART) begin
			prey = item.init_prey;
			pred = item.init_pred;
			now  = t_start;
			r.step_time = now;
		end else if (now >= t_end) begin
			r.step_time = now;
			r.done_res  = 1'b1;
		end else begin
			x = prey;
			y = pred;
			r.step_time = now;
			if (method == METHOD_EULER) begin
				nx = fadd(x, fmul(prey_slope(x, y), dt));
				ny = fadd(y, fmul(pred_slope(nx, y), dt));
			end else begin
				kx = fmul(prey_slope(x, y), dt);
				ky = fmul(pred_slope(x, y), dt);
				xm = fadd(x, kx >>> 1);
				ym = fadd(y, ky >>> 1);
				nx = fadd(x, fmul(prey_slope(xm, ym), dt));
				ny = fadd(y, fmul(pred_slope(xm, ym), dt));
			end
			prey = nx;
			pred = ny;
			now  = fadd(now, dt);
		end
		r.prey_value = prey;
		r.pred_value = pred;
		r.saturated  = clipped;
		return r;
	endfunction

	task automatic check_field(input string field, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a      = UNITY;
			coef_b      = UNITY;
			coef_c      = UNITY;
			coef_d      = UNITY;
			dt          = fix_t'((UNITY + 5) / 10);
			method      = METHOD_EULER;
			t_start     = '0;
			// Forty time units, held at the top of the range for wide fractions.
			t_end       = clip(40 * (longint'(1) << FRAC_BITS));
			prey        = '0;
			pred        = '0;
			now         = '0;
			awaited.delete();
			fail_count  = 0;
			pending     = 0;
			restarts    = 0;
			euler_steps = 0;
			rk2_steps   = 0;
			refused     = 0;
			clamped     = 0;
		end else begin
			// Results go first: a command taken at this edge cannot have its result here yet.
			if (res_valid && !res_stall) begin
				got = res;
				if (awaited.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time, got);
					fail_count++;
				end else begin
					want = awaited.pop_front();
					check_field("step_time", want.step_time, got.step_time);
					check_field("prey_value", want.prey_value, got.prey_value);
					check_field("pred_value", want.pred_value, got.pred_value);
					check_field("done_res", want.done_res, got.done_res);
					check_field("saturated", want.saturated, got.saturated);
				end
			end
			if (cmd_valid && !cmd_stall) begin
				want = integrate(cmd);
				awaited.insert(awaited.size(), want);
				if (cmd.command == CMD_RESTART)
					restarts++;
				else if (want.done_res)
					refused++;
				else if (method == METHOD_EULER)
					euler_steps++;
				else
					rk2_steps++;
				if (want.saturated)
					clamped++;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PREY_GROWTH:    coef_a = cfg_data;
					REG_PREDATION_RATE: coef_b = cfg_data;
					REG_PREDATOR_GAIN:  coef_c = cfg_data;
					REG_PREDATOR_DEATH: coef_d = cfg_data;
					REG_TIME_STEP:      dt = {1'b0, cfg_data[30:0]};
					REG_METHOD:         method = method_t'(cfg_data[0]);
					REG_START_TIME:     t_start = cfg_data;
					REG_END_TIME:       t_end = cfg_data;
					default: ;
				endcase
			end
			pending = awaited.size();
		end
	end

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
module tb;
	import ppi_pkg::*;

	typedef logic signed [31:0] fix_t;

	localparam int   FRAC         = 20;
	localparam fix_t ONE          = fix_t'(1 << FRAC);
	localparam fix_t FIX_MAX      = 32'sh7fffffff;
	localparam fix_t FIX_MIN      = 32'sh80000000;
	localparam int   TARGET_ITEMS = 920;
	// Indexes past the last register must be ignored by the block.
	localparam logic [CFG_IDX_W-1:0] FIRST_UNUSED_REG = CFG_IDX_W'(REG_END_TIME + 1);

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data  = '0;
	logic                 cmd_valid = 1'b0;
	logic                 cmd_stall;
	cmd_item_t            cmd       = '0;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	res_item_t            res;

	int fail_count, pending, restarts, euler_steps, rk2_steps, refused, clamped;

	// When steady is set neither side idles; hold_cycles forces a long receiver stall.
	bit steady      = 1'b0;
	int hold_cycles = 0;
	int sent        = 0;
	int settings    = 0;

	predator_prey_integrator #(.FRAC_BITS(FRAC)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	// The checker sees the same channels as the block and keeps its own model.
	ppi_checker #(.FRAC_BITS(FRAC)) chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.cmd         (cmd),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res         (res),
		.fail_count  (fail_count),
		.pending     (pending),
		.restarts    (restarts),
		.euler_steps (euler_steps),
		.rk2_steps   (rk2_steps),
		.refused     (refused),
		.clamped     (clamped)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Safety net in case the block hangs. The slowest legal run is far shorter.
	initial begin
		#4_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Result side: random stalls, a forced hold-off when asked for, none while steady.
	// All changes happen on the falling edge so the block samples stable values.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				res_stall   <= 1'b1;
				hold_cycles <= hold_cycles - 1;
			end else begin
				res_stall <= !steady && ($urandom_range(99) < 19);
			end
		end
	end

	// Every task below is entered and left just after a falling edge.
	// A write leaves cfg_valid high so back-to-back writes need no gap;
	// the caller lowers it once the batch is done.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// Offers one command transaction, with random idle cycles ahead of it. Valid stays high
	// afterwards so a following command goes out without a bubble.
	task automatic send_item(input cmd_code_t code, input fix_t prey, input fix_t pred);
		while (!steady && ($urandom_range(99) < 19)) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= '{command: code, init_prey: prey, init_pred: pred};
		do @(posedge clk); while (cmd_stall);
		@(negedge clk);
		sent++;
	endtask

	// Drops the command valid and waits until every result is back, so that the
	// block is idle and registers may be written.
	task automatic wait_idle();
		cmd_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		settings++;
	endtask

	// Mostly values of moderate size, with full-range words and the extremes mixed in.
	function automatic fix_t rand_fix(input int unsigned mag);
		case ($urandom_range(7))
			0: return fix_t'($urandom);
			1: begin
				case ($urandom_range(3))
					0: return FIX_MAX;
					1: return FIX_MIN;
					2: return '0;
					default: return -1;
				endcase
			end
			default: return fix_t'(longint'($urandom_range(2 * mag)) - longint'(mag));
		endcase
	endfunction

	// Step sizes: usually small, sometimes zero, the maximum or a full random word
	// (bit 31 of the word must be dropped by the block).
	function automatic logic [31:0] rand_dt();
		case ($urandom_range(19))
			0: return '0;
			1: return 32'h7fffffff;
			2, 3: return $urandom;
			default: return $urandom_range(ONE / 4, 1000);
		endcase
	endfunction

	initial begin
		logic [31:0] dt_word;
		fix_t        t0;
		longint      t_stop;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings (Euler, dt of 0.1): a normal start, then the population extremes.
		// Payloads of step commands are ignored, so they carry extreme bits as well.
		send_item(CMD_RESTART, ONE, ONE / 2);
		send_item(CMD_STEP, FIX_MAX, FIX_MIN);
		send_item(CMD_STEP, '0, '0);
		send_item(CMD_RESTART, FIX_MAX, FIX_MAX);
		send_item(CMD_STEP, '0, '0);
		send_item(CMD_RESTART, FIX_MIN, FIX_MIN);
		send_item(CMD_STEP, FIX_MIN, FIX_MAX);
		send_item(CMD_RESTART, FIX_MIN, FIX_MAX);
		send_item(CMD_STEP, '0, '0);

		// Midpoint method with extreme coefficients, so that nearly every product clamps.
		wait_idle();
		write_reg(REG_METHOD, METHOD_RK2);
		write_reg(REG_PREY_GROWTH, FIX_MAX);
		write_reg(REG_PREDATION_RATE, FIX_MIN);
		write_reg(REG_PREDATOR_GAIN, FIX_MAX);
		write_reg(REG_PREDATOR_DEATH, FIX_MIN);
		cfg_valid <= 1'b0;
		send_item(CMD_RESTART, 3 * ONE / 4, 5 * ONE / 4);
		send_item(CMD_STEP, '0, '0);
		send_item(CMD_STEP, '0, '0);

		// A zero step size still runs the update but leaves the time where it is.
		wait_idle();
		write_reg(REG_PREY_GROWTH, ONE);
		write_reg(REG_PREDATION_RATE, ONE);
		write_reg(REG_PREDATOR_GAIN, ONE);
		write_reg(REG_PREDATOR_DEATH, ONE);
		write_reg(REG_TIME_STEP, '0);
		cfg_valid <= 1'b0;
		send_item(CMD_RESTART, ONE, ONE);
		send_item(CMD_STEP, '0, '0);
		send_item(CMD_STEP, '0, '0);

		// Time just below the top of the range with the largest step: the time advance
		// clamps, and the next step is refused at the end time. A write to an index past
		// the register list goes in between and must change nothing.
		wait_idle();
		write_reg(REG_METHOD, METHOD_EULER);
		write_reg(REG_TIME_STEP, 32'hffffffff);
		write_reg(REG_START_TIME, FIX_MAX - 1);
		write_reg(FIRST_UNUSED_REG, '0);
		write_reg(REG_END_TIME, FIX_MAX);
		cfg_valid <= 1'b0;
		send_item(CMD_RESTART, ONE, ONE);
		send_item(CMD_STEP, '0, '0);
		send_item(CMD_STEP, '0, '0);

		// Start already at the end: the very first step is refused.
		wait_idle();
		write_reg(REG_START_TIME, FIX_MIN);
		write_reg(REG_END_TIME, FIX_MIN);
		cfg_valid <= 1'b0;
		send_item(CMD_RESTART, -ONE, 2 * ONE);
		send_item(CMD_STEP, '0, '0);

		// Random phases. Each one programs every register, then runs a few trajectories.
		// The end time is mostly placed a few steps past the start, so that trajectories
		// run into the end and get refused, instead of stopping at once or never.
		while (sent < TARGET_ITEMS) begin
			wait_idle();
			@(posedge clk);
			steady <= (settings >= 14) && (settings < 20);
			// Once, the receiver holds off for a long time while commands keep coming,
			// so the block backs up and stalls its command input.
			if (settings == 8)
				hold_cycles <= 400;
			@(negedge clk);

			dt_word = rand_dt();
			t0      = rand_fix(64 * ONE);
			if ($urandom_range(5) == 0) begin
				t_stop = rand_fix(64 * ONE);
			end else begin
				t_stop = longint'(t0) + longint'($urandom_range(24)) * longint'(dt_word[30:0]);
				if (t_stop > longint'(FIX_MAX))
					t_stop = FIX_MAX;
			end
			write_reg(REG_PREY_GROWTH, rand_fix(4 * ONE));
			write_reg(REG_PREDATION_RATE, rand_fix(4 * ONE));
			write_reg(REG_PREDATOR_GAIN, rand_fix(4 * ONE));
			write_reg(REG_PREDATOR_DEATH, rand_fix(4 * ONE));
			write_reg(REG_TIME_STEP, dt_word);
			// Only bit 0 selects the method; the other bits are random noise.
			write_reg(REG_METHOD, $urandom);
			write_reg(REG_START_TIME, t0);
			write_reg(REG_END_TIME, fix_t'(t_stop));
			if ($urandom_range(3) == 0)
				write_reg(CFG_IDX_W'(FIRST_UNUSED_REG + $urandom_range(7)), $urandom);
			cfg_valid <= 1'b0;

			// During the hold-off enough commands are offered to back the block up.
			repeat ((settings == 8) ? 3 : $urandom_range(1, 3)) begin
				send_item(CMD_RESTART, rand_fix(8 * ONE), rand_fix(8 * ONE));
				repeat ($urandom_range(1, 12))
					send_item(CMD_STEP, fix_t'($urandom), fix_t'($urandom));
			end
		end

		// Drain, then leave room for the longest step in case a stray result shows up.
		wait_idle();
		repeat (60) @(negedge clk);

		$display("Ran %0d commands over %0d register settings: %0d restarts, %0d Euler steps,",
			sent, settings, restarts, euler_steps);
		$display("%0d midpoint steps, %0d steps refused at the end time, %0d results clamped.",
			rk2_steps, refused, clamped);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

/* predator_prey_integrator.f */
+incdir+hw/rtl
hw/rtl/ppi_pkg.sv
hw/rtl/predator_prey_integrator.sv
test/ppi_checker.sv
test/tb.sv
